// File: hdl/revolution_mesh_face_indexer_unit_macros.svh
// Assertion helpers for the face indexer checker.
// Both macros expect clk and arst_n in the scope where they are used.
`ifndef REVOLUTION_MESH_FACE_INDEXER_UNIT_MACROS_SVH
`define REVOLUTION_MESH_FACE_INDEXER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RMFI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define RMFI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/rmfi_pkg.sv
`default_nettype none
package rmfi_pkg;

	localparam int COORD_W   = 8;
	localparam int SEG_W     = 9;
	localparam int IDX_W     = 17;
	localparam int CFG_IDX_W = 3;
	localparam int SEG_TOP   = (1 << SEG_W) - 1;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [SEG_W-1:0]   seg_t;
	typedef logic [IDX_W-1:0]   idx_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEGMENTS_U = 3'd0,
		REG_SEGMENTS_V = 3'd1,
		REG_OPEN_U     = 3'd2,
		REG_POLE_FIRST = 3'd3,
		REG_POLE_LAST  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		seg_t segments_u;
		seg_t segments_v;
		logic open_u;
		logic pole_first;
		logic pole_last;
	} cfg_t;

	typedef struct packed {
		idx_t vertex_a;
		idx_t vertex_b;
		idx_t vertex_c;
		idx_t texel_a;
		idx_t texel_b;
		idx_t texel_c;
		logic out_of_grid;
		logic last_face;
	} face_t;

endpackage
`default_nettype wire

// File: hdl/rmfi_cfg_if.sv
`default_nettype none
interface rmfi_cfg_if
	import rmfi_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	seg_t                 data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/rmfi_cell_if.sv
`default_nettype none
interface rmfi_cell_if
	import rmfi_pkg::*;
;
	logic   valid;
	logic   ready;
	coord_t column;
	coord_t row;

	modport source (output valid, output column, output row, input ready);
	modport sink (input valid, input column, input row, output ready);
endinterface
`default_nettype wire

// File: hdl/rmfi_face_if.sv
`default_nettype none
interface rmfi_face_if
	import rmfi_pkg::*;
;
	logic valid;
	logic ready;
	idx_t vertex_a;
	idx_t vertex_b;
	idx_t vertex_c;
	idx_t texel_a;
	idx_t texel_b;
	idx_t texel_c;
	logic out_of_grid;
	logic last_face;

	modport source (
		output valid, output vertex_a, output vertex_b, output vertex_c,
		output texel_a, output texel_b, output texel_c,
		output out_of_grid, output last_face, input ready
	);
	modport sink (
		input valid, input vertex_a, input vertex_b, input vertex_c,
		input texel_a, input texel_b, input texel_c,
		input out_of_grid, input last_face, output ready
	);
endinterface
`default_nettype wire

// File: hdl/rmfi_face_calc.sv
`default_nettype none
module rmfi_face_calc
	import rmfi_pkg::*;
#(
	parameter int MAX_SEGMENTS = 256
) (
	input  var cfg_t   cfg,
	input  var coord_t column,
	input  var coord_t row,
	output face_t      face0,
	output face_t      face1
);

	localparam int   MaxClip = (MAX_SEGMENTS > SEG_TOP) ? SEG_TOP : MAX_SEGMENTS;
	localparam seg_t MaxSeg  = SEG_W'(MaxClip);

	seg_t                su;
	seg_t                sv;
	seg_t                col9;
	seg_t                row9;
	logic                oob;
	logic                last_col;
	logic [1:0]          poles;
	logic [SEG_W:0]      percol;
	logic [SEG_W:0]      trow;
	idx_t                pv;
	idx_t                pt;
	idx_t                rr;
	idx_t                o1;
	idx_t                o2;
	idx_t                o1s;
	idx_t                o2s;
	idx_t                ct;
	idx_t                t0;
	idx_t                t1;

	// clamp oversized counts
	assign su   = (cfg.segments_u > MaxSeg) ? MaxSeg : cfg.segments_u;
	assign sv   = (cfg.segments_v > MaxSeg) ? MaxSeg : cfg.segments_v;
	assign col9 = {1'b0, column};
	assign row9 = {1'b0, row};
	assign oob  = (col9 >= su) || (row9 >= sv);

	assign poles    = {1'b0, cfg.pole_first} + {1'b0, cfg.pole_last};
	assign percol   = {1'b0, sv} + (SEG_W+1)'(1) - {{(SEG_W-1){1'b0}}, poles};
	assign trow     = {1'b0, sv} + (SEG_W+1)'(1);
	assign last_col = (col9 == su - SEG_W'(1));

	assign pv = IDX_W'(column) * IDX_W'(percol);
	assign pt = IDX_W'(column) * IDX_W'(trow);
	assign rr = IDX_W'(row);
	assign ct = pt;

	assign o1  = IDX_W'(poles) + pv;
	assign o2  = (!cfg.open_u && last_col) ? IDX_W'(poles) : o1 + IDX_W'(percol);
	// rows past the first pole sit one lower
	assign o1s = cfg.pole_first ? o1 - IDX_W'(1) : o1;
	assign o2s = cfg.pole_first ? o2 - IDX_W'(1) : o2;

	assign t0 = ct + rr;
	assign t1 = t0 + IDX_W'(trow) - IDX_W'(cfg.pole_first && last_col);

	always_comb begin
		face0 = '0;
		face1 = '0;
		face0.last_face = 1'b1;
		face1.last_face = 1'b1;
		if (oob) begin
			face0.out_of_grid = 1'b1;
		end else if (cfg.pole_first && row == '0) begin
			face0.vertex_a = o1;
			face0.vertex_c = o2;
			face0.texel_a  = ct + IDX_W'(1);
			face0.texel_b  = ct;
			face0.texel_c  = ct + IDX_W'(1) + IDX_W'(trow) - IDX_W'(last_col);
		end else if (cfg.pole_last && row9 == sv - SEG_W'(1)) begin
			face0.vertex_a = o1s + rr;
			face0.vertex_b = o2s + rr;
			face0.vertex_c = IDX_W'(cfg.pole_first);
			face0.texel_a  = t0;
			face0.texel_b  = t1;
			face0.texel_c  = t0 + IDX_W'(1);
		end else begin
			face0.vertex_a  = o1s + rr;
			face0.vertex_b  = o2s + rr;
			face0.vertex_c  = o2s + rr + IDX_W'(1);
			face0.texel_a   = t0;
			face0.texel_b   = t1;
			face0.texel_c   = t1 + IDX_W'(1);
			face0.last_face = 1'b0;
			face1.vertex_a  = o1s + rr;
			face1.vertex_b  = o2s + rr + IDX_W'(1);
			face1.vertex_c  = o1s + rr + IDX_W'(1);
			face1.texel_a   = t0;
			face1.texel_b   = t1 + IDX_W'(1);
			face1.texel_c   = t0 + IDX_W'(1);
		end
	end

endmodule
`default_nettype wire

// File: hdl/revolution_mesh_face_indexer_unit.sv
// A cell accepted into the stage-1 register moves into the result buffer once that buffer frees up.
// Throughput: one result per cycle while face.ready is high; an inner cell gives two faces,
// a pole or off-grid cell one; the single result port drains the two-face buffer one face a cycle.
// Reset (arst_n low, asynchronous): pipeline and result buffer empty, registers back to
// segments_u=16, segments_v=8, open_u=0, pole_first=0, pole_last=0.
`default_nettype none
module revolution_mesh_face_indexer_unit
	import rmfi_pkg::*;
#(
	parameter int MAX_SEGMENTS = 256
) (
	input  wire         clk,
	input  wire         arst_n,
	rmfi_cfg_if.sink    cfg,
	rmfi_cell_if.sink   coord,
	rmfi_face_if.source face
);

	// ------------------------------------------------------------------
	// Configuration registers. The port never stalls; unknown indexes
	// are dropped.
	// ------------------------------------------------------------------
	cfg_t cfg_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.segments_u <= SEG_W'(16);
			cfg_q.segments_v <= SEG_W'(8);
			cfg_q.open_u     <= 1'b0;
			cfg_q.pole_first <= 1'b0;
			cfg_q.pole_last  <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SEGMENTS_U: cfg_q.segments_u <= cfg.data;
				REG_SEGMENTS_V: cfg_q.segments_v <= cfg.data;
				REG_OPEN_U:     cfg_q.open_u     <= cfg.data[0];
				REG_POLE_FIRST: cfg_q.pole_first <= cfg.data[0];
				REG_POLE_LAST:  cfg_q.pole_last  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: input register holding the cell coordinates.
	// ------------------------------------------------------------------
	logic   s1_valid_q;
	coord_t column_s1;
	coord_t row_s1;

	// ------------------------------------------------------------------
	// Result buffer: up to two faces of one cell, drained in order.
	// sel_q picks which face is on the port.
	// ------------------------------------------------------------------
	logic  out_valid_q;
	logic  sel_q;
	face_t face0_q;
	face_t face1_q;
	face_t cur;
	face_t calc0;
	face_t calc1;

	logic face_take;
	logic buf_free;
	logic s1_move;
	logic cell_take;

	assign cur       = sel_q ? face1_q : face0_q;
	assign face_take = out_valid_q && face.ready;
	// buffer frees up on the transaction that moves the cell's last face
	assign buf_free  = !out_valid_q || (face_take && cur.last_face);
	assign s1_move   = s1_valid_q && buf_free;
	// stage 1 takes a new cell when empty, even while the buffer still holds a result, or as its cell moves on
	assign coord.ready = !s1_valid_q || buf_free;
	assign cell_take   = coord.valid && coord.ready;

	rmfi_face_calc #(
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_calc (
		.cfg    (cfg_q),
		.column (column_s1),
		.row    (row_s1),
		.face0  (calc0),
		.face1  (calc1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
		end else begin
			// stage 1 occupancy
			if (cell_take) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			// result buffer: load a fresh cell, advance to the second face,
			// or drain
			if (s1_move) begin
				out_valid_q <= 1'b1;
				sel_q       <= 1'b0;
			end else if (face_take) begin
				if (cur.last_face) begin
					out_valid_q <= 1'b0;
				end else begin
					sel_q <= 1'b1;
				end
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (cell_take) begin
			column_s1 <= coord.column;
			row_s1    <= coord.row;
		end
		if (s1_move) begin
			face0_q <= calc0;
			face1_q <= calc1;
		end
	end

	assign face.valid       = out_valid_q;
	assign face.vertex_a    = cur.vertex_a;
	assign face.vertex_b    = cur.vertex_b;
	assign face.vertex_c    = cur.vertex_c;
	assign face.texel_a     = cur.texel_a;
	assign face.texel_b     = cur.texel_b;
	assign face.texel_c     = cur.texel_c;
	assign face.out_of_grid = cur.out_of_grid;
	assign face.last_face   = cur.last_face;

endmodule
`default_nettype wire

// File: hdl/rmfi_checker.sv
`default_nettype none
`include "revolution_mesh_face_indexer_unit_macros.svh"
module rmfi_checker
	import rmfi_pkg::*;
(
	input wire      clk,
	input wire      arst_n,
	input wire      face_valid,
	input wire      face_ready,
	input var idx_t vertex_a,
	input var idx_t vertex_b,
	input var idx_t vertex_c,
	input var idx_t texel_a,
	input var idx_t texel_b,
	input var idx_t texel_c,
	input wire      out_of_grid,
	input wire      last_face
);

	logic               first_take;
	logic               idx_zero;
	logic [6*IDX_W+1:0] payload;

	assign first_take = face_valid && face_ready && !last_face;
	assign idx_zero   = vertex_a == '0 && vertex_b == '0 && vertex_c == '0
		&& texel_a == '0 && texel_b == '0 && texel_c == '0;
	assign payload    = {vertex_a, vertex_b, vertex_c, texel_a, texel_b, texel_c,
		out_of_grid, last_face};

	// off-grid result is a single transaction with all indexes zero
	`RMFI_ASSERT_NOW(a_oob_zero, face_valid && out_of_grid, last_face && idx_zero, "off-grid result not clean")
	// first face of an inner cell is always followed by its second face
	`RMFI_ASSERT_NEXT(a_second_face, first_take, face_valid && !out_of_grid, "second face missing")
	// both faces of an inner cell share the corner o1s+r and texel t0
	`RMFI_ASSERT_NEXT(a_shared_corner, first_take, $stable(vertex_a) && $stable(texel_a), "faces disagree")
	// stalled result holds
	`RMFI_ASSERT_NEXT(a_hold, face_valid && !face_ready, face_valid && $stable(payload), "stalled result changed")

endmodule

bind revolution_mesh_face_indexer_unit rmfi_checker u_rmfi_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.face_valid  (face.valid),
	.face_ready  (face.ready),
	.vertex_a    (face.vertex_a),
	.vertex_b    (face.vertex_b),
	.vertex_c    (face.vertex_c),
	.texel_a     (face.texel_a),
	.texel_b     (face.texel_b),
	.texel_c     (face.texel_c),
	.out_of_grid (face.out_of_grid),
	.last_face   (face.last_face)
);
`default_nettype wire
